// ===== rtl/core/shdd_pkg.sv =====
// ----------------------------------------------------------------------------
// shdd_pkg: shared types and constants for the staggered heater duty driver
// Command and output type codes, field layout of the input tdata, defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package shdd_pkg;

	// Default build
	localparam int NUM_OUTPUTS_DEF  = 6;
	localparam int DUTY_PERIOD_DEF  = 100;
	localparam int STAGGER_STEP_DEF = 65;

	// Fixed field widths
	localparam int CMD_W    = 3;
	localparam int KIND_W   = 2;
	localparam int DUTY_W   = 7;
	localparam int NUM_KINDS = 3;
	localparam int TYPE_W   = 3;

	// Input tdata layout, lowest bit first
	localparam int KIND_LSB  = 0;
	localparam int DUTY_LSB  = KIND_LSB + KIND_W;
	localparam int ELON_BIT  = DUTY_LSB + DUTY_W;
	localparam int CONV_BIT  = ELON_BIT + 1;
	localparam int COOL_BIT  = CONV_BIT + 1;
	localparam int FAN_BIT   = COOL_BIT + 1;
	localparam int S_TDATA_W = ((FAN_BIT + 1 + 7) / 8) * 8;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_TYPES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK  = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK     = 3'd0,
		CMD_SET_DUTY = 3'd1,
		CMD_SET_OVEN = 3'd2,
		CMD_CONV_FAN = 3'd3,
		CMD_COOL_FAN = 3'd4,
		CMD_RESTART  = 3'd5
	} cmd_t;

	typedef enum logic [TYPE_W-1:0] {
		OT_UNUSED = 3'd0,
		OT_BOTTOM = 3'd1,
		OT_TOP    = 3'd2,
		OT_BOOST  = 3'd3,
		OT_CONV   = 3'd4,
		OT_COOL   = 3'd5
	} otype_t;

	// Codes 6 and 7 behave as unused
	function automatic otype_t decode_type(input logic [TYPE_W-1:0] raw);
		otype_t t;
		case (raw)
			3'd1:    t = OT_BOTTOM;
			3'd2:    t = OT_TOP;
			3'd3:    t = OT_BOOST;
			3'd4:    t = OT_CONV;
			3'd5:    t = OT_COOL;
			default: t = OT_UNUSED;
		endcase
		return t;
	endfunction

	function automatic logic is_heater(input otype_t t);
		return (t == OT_BOTTOM) || (t == OT_TOP) || (t == OT_BOOST);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/staggered_heater_duty_driver.sv =====
// ----------------------------------------------------------------------------
// staggered_heater_duty_driver: multichannel slow PWM for oven outputs
// Heater outputs run a time-proportional PWM with staggered phases; fans are
// switched by command; pin levels pass through a per-output inversion mask.
// ----------------------------------------------------------------------------
// Takes one command transaction per clock while not stalled and returns one
// result transaction per command, in order. The accepting edge loads the input
// register. The update stage fires once the result register is free or being
// read; all phase counters, duties and output levels are then updated in
// parallel and the result register is loaded, which raises m_tvalid.
// Throughput is one command per cycle while results are taken. The input
// stalls only while a result is held by m_tready low with a command already
// waiting in the input register.
// Configuration writes are always taken (cfg_ready is tied high) and are
// meant to happen while the block has no command in flight.
`default_nettype none

module staggered_heater_duty_driver
#(
	parameter int NUM_OUTPUTS  = shdd_pkg::NUM_OUTPUTS_DEF,
	parameter int DUTY_PERIOD  = shdd_pkg::DUTY_PERIOD_DEF,
	parameter int STAGGER_STEP = shdd_pkg::STAGGER_STEP_DEF,
	// derived, not meant to be overridden
	parameter int AW           = $clog2(NUM_OUTPUTS + 1),
	parameter int M_TDATA_W    = ((NUM_OUTPUTS + AW + 1 + 7) / 8) * 8
)
(
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,

	// command stream
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// tdata: element_kind[1:0], duty_value[8:2], elements_on[9],
	//        convection_fan_on[10], cooling_fan_on[11], fan_on[12], zero pad
	input  wire logic [shdd_pkg::S_TDATA_W-1:0]        s_tdata,
	// tuser: command[2:0]
	input  wire logic [shdd_pkg::CMD_W-1:0]            s_tuser,

	// result stream
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// tdata: pin_levels[N-1:0], active_count[N+AW-1:N], has_heater[N+AW],
	//        zero pad
	output logic [M_TDATA_W-1:0]                       m_tdata,

	// configuration write channel
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [shdd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [3*NUM_OUTPUTS-1:0]              cfg_data
);

	import shdd_pkg::*;

	// Phase counter holds 0 .. DUTY_PERIOD-1
	localparam int CW   = $clog2(DUTY_PERIOD);
	localparam int CMPW = (CW > DUTY_W) ? CW : DUTY_W;

	// ---------------- configuration ----------------
	logic [3*NUM_OUTPUTS-1:0] types_q;
	logic [NUM_OUTPUTS-1:0]   mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			types_q <= '0;
			mask_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_OUTPUT_TYPES: types_q <= cfg_data;
				REG_INVERT_MASK:  mask_q  <= cfg_data[NUM_OUTPUTS-1:0];
				default:          ;
			endcase
		end
	end

	// ---------------- input register stage ----------------
	logic                vld_s1;
	logic [CMD_W-1:0]    cmd_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [DUTY_W-1:0]   duty_s1;
	logic                elon_s1;
	logic                conv_s1;
	logic                cool_s1;
	logic                fan_s1;

	logic adv;      // update stage may fire / result register may load
	logic fire;     // update stage consumes the staged command

	logic m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;

	assign adv      = !m_valid_q || m_tready;
	assign fire     = vld_s1 && adv;
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			kind_s1 <= s_tdata[KIND_LSB +: KIND_W];
			duty_s1 <= s_tdata[DUTY_LSB +: DUTY_W];
			elon_s1 <= s_tdata[ELON_BIT];
			conv_s1 <= s_tdata[CONV_BIT];
			cool_s1 <= s_tdata[COOL_BIT];
			fan_s1  <= s_tdata[FAN_BIT];
		end
	end

	// ---------------- state ----------------
	logic [CW-1:0]          ctr_q  [NUM_OUTPUTS];
	logic [DUTY_W-1:0]      duty_q [NUM_KINDS];
	logic [NUM_OUTPUTS-1:0] on_q;

	// Stagger phase of output i: STAGGER_STEP*(i+1) mod DUTY_PERIOD
	logic [CW-1:0] stg_c [NUM_OUTPUTS];

	for (genvar g = 0; g < NUM_OUTPUTS; g++) begin : g_stg
		localparam int STG = (STAGGER_STEP * (g + 1)) % DUTY_PERIOD;
		assign stg_c[g] = CW'(STG);
	end

	// ---------------- update logic ----------------
	otype_t                 typ   [NUM_OUTPUTS];
	logic [NUM_OUTPUTS-1:0] act;
	logic [NUM_OUTPUTS-1:0] htr;
	logic [AW-1:0]          act_cnt;
	logic                   has_htr;

	logic [CW-1:0]          ctr_d  [NUM_OUTPUTS];
	logic [DUTY_W-1:0]      duty_d [NUM_KINDS];
	logic [NUM_OUTPUTS-1:0] on_d;

	// Type decode and the leading run of used outputs
	always_comb begin
		logic run;
		run     = 1'b1;
		act_cnt = '0;
		for (int i = 0; i < NUM_OUTPUTS; i++) begin
			typ[i]  = decode_type(types_q[TYPE_W*i +: TYPE_W]);
			run     = run && (typ[i] != OT_UNUSED);
			act[i]  = run;
			htr[i]  = is_heater(typ[i]);
			act_cnt = act_cnt + AW'(act[i]);
		end
		has_htr = |(act & htr);
	end

	always_comb begin
		logic [TYPE_W-1:0] k3;
		logic [CMPW-1:0]   c_w;
		logic [CMPW-1:0]   d_w;
		logic [CW:0]       nx;
		k3  = '0;
		c_w = '0;
		d_w = '0;
		nx  = '0;
		ctr_d  = ctr_q;
		duty_d = duty_q;
		on_d   = on_q;
		case (cmd_t'(cmd_s1))
			CMD_TICK: begin
				for (int i = 0; i < NUM_OUTPUTS; i++) begin
					if (act[i] && htr[i]) begin
						k3  = TYPE_W'(typ[i]) - TYPE_W'(1);
						c_w = CMPW'(ctr_q[i]);
						d_w = CMPW'(duty_q[k3[1:0]]);
						if (c_w >= d_w) begin
							on_d[i] = 1'b0;
						end else if (c_w == '0 && d_w != '0) begin
							on_d[i] = 1'b1;
						end
						nx = (CW+1)'(ctr_q[i]) + (CW+1)'(1);
						if (nx >= (CW+1)'(DUTY_PERIOD)) begin
							ctr_d[i] = '0;
						end else begin
							ctr_d[i] = nx[CW-1:0];
						end
					end
				end
			end
			CMD_SET_DUTY: begin
				// kind 3 names no heater and is dropped
				if (kind_s1 < KIND_W'(NUM_KINDS)) begin
					duty_d[kind_s1] = duty_s1;
				end
			end
			CMD_SET_OVEN: begin
				if (!elon_s1) begin
					for (int k = 0; k < NUM_KINDS; k++) duty_d[k] = '0;
				end
				for (int i = 0; i < NUM_OUTPUTS; i++) begin
					if (act[i]) begin
						if (typ[i] == OT_CONV) begin
							on_d[i] = conv_s1;
						end else if (typ[i] == OT_COOL) begin
							on_d[i] = cool_s1;
						end else if (!elon_s1) begin
							on_d[i] = 1'b0;
						end
					end
				end
			end
			CMD_CONV_FAN: begin
				for (int i = 0; i < NUM_OUTPUTS; i++) begin
					if (act[i] && typ[i] == OT_CONV) on_d[i] = fan_s1;
				end
			end
			CMD_COOL_FAN: begin
				for (int i = 0; i < NUM_OUTPUTS; i++) begin
					if (act[i] && typ[i] == OT_COOL) on_d[i] = fan_s1;
				end
			end
			CMD_RESTART: begin
				for (int k = 0; k < NUM_KINDS; k++) duty_d[k] = '0;
				// output 0 is always restaged, even when nothing is active
				for (int i = 0; i < NUM_OUTPUTS; i++) begin
					if (i == 0 || act[i]) ctr_d[i] = stg_c[i];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q  <= stg_c;
			for (int k = 0; k < NUM_KINDS; k++) duty_q[k] <= '0;
			on_q   <= '0;
		end else if (fire) begin
			ctr_q  <= ctr_d;
			duty_q <= duty_d;
			on_q   <= on_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_data_q <= M_TDATA_W'({has_htr, act_cnt, on_d ^ mask_q});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/shdd_checker.sv =====
// ----------------------------------------------------------------------------
// shdd_checker: port-level assertions for the staggered heater duty driver
// Watches the top-level ports only; attached by the bind at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module shdd_checker
#(
	parameter int NUM_OUTPUTS = shdd_pkg::NUM_OUTPUTS_DEF,
	parameter int AW          = $clog2(NUM_OUTPUTS + 1),
	parameter int M_TDATA_W   = ((NUM_OUTPUTS + AW + 1 + 7) / 8) * 8
)
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);

	logic [AW-1:0] cnt;
	logic          heat;

	assign cnt  = m_tdata[NUM_OUTPUTS +: AW];
	assign heat = m_tdata[NUM_OUTPUTS + AW];

	// input only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a held result");

	// active count never exceeds the number of outputs
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cnt <= AW'(NUM_OUTPUTS)))
		else $error("active count out of range");

	// no heater can be reported when no output is active
	a_heat_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && cnt == '0) |-> !heat)
		else $error("heater flag with no active output");

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

endmodule

bind staggered_heater_duty_driver shdd_checker #(
	.NUM_OUTPUTS (NUM_OUTPUTS)
) u_shdd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/staggered_heater_duty_driver_tb.sv =====
// ----------------------------------------------------------------------------
// staggered_heater_duty_driver_tb: self-checking bench for the heater driver
// Streams command transactions into the block under random valid/ready gaps,
// predicts every result transaction in step, and compares it field by field.
// ----------------------------------------------------------------------------
module staggered_heater_duty_driver_tb;
	import shdd_pkg::*;

	localparam int NOUT   = NUM_OUTPUTS_DEF;
	localparam int PERIOD = DUTY_PERIOD_DEF;
	localparam int STEP   = STAGGER_STEP_DEF;
	localparam int ACT_W  = $clog2(NOUT + 1);
	localparam int M_W    = ((NOUT + ACT_W + 1 + 7) / 8) * 8;
	localparam int TYPES_W = TYPE_W * NOUT;

	// command codes the block must ignore
	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
	// heater kinds for set duty; the spare kind is ignored by the block
	localparam logic [KIND_W-1:0] KIND_BOTTOM = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TOP    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BOOST  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;
	// output type codes that decode as unused
	localparam logic [TYPE_W-1:0] TYPE_SPARE_A = 3'd6;
	localparam logic [TYPE_W-1:0] TYPE_SPARE_B = 3'd7;

	localparam int STALL_LIMIT = 1000;   // cycles with no transaction at all

	typedef struct {
		logic [CMD_W-1:0]  command;
		logic [KIND_W-1:0] kind;
		logic [DUTY_W-1:0] duty;
		logic              elements_on;
		logic              conv_on;
		logic              cool_on;
		logic              fan_on;
		bit                wait_idle;   // hold this one back until all results are in
	} oven_cmd_t;

	typedef struct {
		logic [NOUT-1:0]  pins;
		logic [ACT_W-1:0] active;
		logic             heater;
	} oven_status_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [CMD_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TYPES_W-1:0] cfg_data;

	staggered_heater_duty_driver uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Predictor state: the block's registers as this bench believes them
	logic [TYPES_W-1:0] cfg_types;
	logic [NOUT-1:0]    cfg_invert;
	logic [DUTY_W-1:0]  pwm_phase [NOUT];
	logic [DUTY_W-1:0]  heat_duty [NUM_KINDS];
	logic [NOUT-1:0]    level_bits;

	oven_cmd_t    pending [$];      // commands waiting for the driver
	oven_status_t status_due [$];   // predicted results, oldest first
	oven_cmd_t    cur_item;         // command now on the slave side

	int  n_queued, n_accepted, n_checked, n_ticks, n_layouts, mismatches;
	int  in_gap, out_gap, idle_cycles;
	bit  in_taken;   // set at the edge that took cur_item, consumed at the next fall
	bit  quiet;      // no idling on either side

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Type of output i, with the two spare codes folded into unused
	function automatic logic [TYPE_W-1:0] slot_type(input int i);
		logic [TYPE_W-1:0] raw;
		raw = cfg_types[TYPE_W*i +: TYPE_W];
		return (raw > OT_COOL) ? OT_UNUSED : raw;
	endfunction

	// Apply one command to the predicted state and return the status it yields
	function automatic oven_status_t advance_oven(input oven_cmd_t c);
		oven_status_t st;
		int active;
		bit stop;
		logic [TYPE_W-1:0] t;
		logic [DUTY_W-1:0] ph, d;
		active = 0;
		stop = 0;
		// active set is the leading run of used outputs, under the present layout
		for (int i = 0; i < NOUT; i++) begin
			if (!stop && slot_type(i) != OT_UNUSED)
				active++;
			else
				stop = 1;
		end
		case (c.command)
			CMD_TICK: begin
				n_ticks++;
				for (int i = 0; i < active; i++) begin
					t = slot_type(i);
					if (t >= OT_BOTTOM && t <= OT_BOOST) begin
						ph = pwm_phase[i];
						d = heat_duty[t - OT_BOTTOM];
						// off once the counter reaches the duty, on at the period start
						if (ph >= d)
							level_bits[i] = 1'b0;
						else if (ph == 0 && d != 0)
							level_bits[i] = 1'b1;
						pwm_phase[i] = (ph >= PERIOD - 1) ? '0 : ph + 1'b1;
					end
				end
			end
			CMD_SET_DUTY: begin
				if (c.kind != KIND_SPARE)
					heat_duty[c.kind] = c.duty;
			end
			CMD_SET_OVEN: begin
				if (!c.elements_on)
					for (int k = 0; k < NUM_KINDS; k++)
						heat_duty[k] = '0;
				for (int i = 0; i < active; i++) begin
					t = slot_type(i);
					if (t == OT_CONV)
						level_bits[i] = c.conv_on;
					else if (t == OT_COOL)
						level_bits[i] = c.cool_on;
					else if (!c.elements_on)
						level_bits[i] = 1'b0;
				end
			end
			CMD_CONV_FAN, CMD_COOL_FAN: begin
				for (int i = 0; i < active; i++)
					if (slot_type(i) == ((c.command == CMD_CONV_FAN) ? OT_CONV : OT_COOL))
						level_bits[i] = c.fan_on;
			end
			CMD_RESTART: begin
				// duties cleared; output 0 and every active output re-staggered
				for (int k = 0; k < NUM_KINDS; k++)
					heat_duty[k] = '0;
				for (int i = 0; i < NOUT; i++)
					if (i == 0 || i < active)
						pwm_phase[i] = DUTY_W'((STEP * (i + 1)) % PERIOD);
			end
			default: ;   // spare commands change nothing
		endcase
		st.pins = level_bits ^ cfg_invert;
		st.active = ACT_W'(active);
		st.heater = 1'b0;
		for (int i = 0; i < active; i++)
			if (slot_type(i) >= OT_BOTTOM && slot_type(i) <= OT_BOOST)
				st.heater = 1'b1;
		return st;
	endfunction

	// ------------------------------------------------------------------------
	// Clock, driver, monitor, watchdog
	// ------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Slave side: inputs change on the falling edge only, one NBA per signal
	always @(negedge clk) begin : feed
		logic [S_TDATA_W-1:0] word;
		if (s_tvalid && !in_taken) begin
			// transaction still offered, hold everything
		end else if (!quiet && in_gap > 0) begin
			in_gap--;
			s_tvalid <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			in_gap = $urandom_range(0, 3);   // start an idle burst; in_gap further falls stay idle
			s_tvalid <= 1'b0;
		end else if (pending.size() > 0 &&
				!(pending[0].wait_idle && n_checked != n_accepted)) begin
			cur_item = pending.pop_front();
			word = '0;
			word[KIND_LSB +: KIND_W] = cur_item.kind;
			word[DUTY_LSB +: DUTY_W] = cur_item.duty;
			word[ELON_BIT] = cur_item.elements_on;
			word[CONV_BIT] = cur_item.conv_on;
			word[COOL_BIT] = cur_item.cool_on;
			word[FAN_BIT]  = cur_item.fan_on;
			s_tdata  <= word;
			s_tuser  <= cur_item.command;
			s_tvalid <= 1'b1;
		end else begin
			s_tvalid <= 1'b0;
		end
		in_taken = 1'b0;
	end

	// Master side backpressure, same burst scheme
	always @(negedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (out_gap > 0) begin
			out_gap--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			out_gap = $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Command accepted: predict its result right away
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			status_due.push_back(advance_oven(cur_item));
			n_accepted++;
			in_taken = 1'b1;
		end
	end

	// Result accepted: compare with the oldest prediction
	always @(posedge clk) begin : check
		oven_status_t want;
		logic [NOUT-1:0]  got_pins;
		logic [ACT_W-1:0] got_active;
		logic             got_heater;
		if (arst_n && m_tvalid && m_tready) begin
			got_pins   = m_tdata[NOUT-1:0];
			got_active = m_tdata[NOUT +: ACT_W];
			got_heater = m_tdata[NOUT + ACT_W];
			if (status_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result transaction, expected none, actual tdata %h",
					$time, m_tdata);
			end else begin
				want = status_due.pop_front();
				n_checked++;
				if (got_pins !== want.pins) begin
					mismatches++;
					$display("%0t: pin_levels expected %b actual %b", $time, want.pins, got_pins);
				end
				if (got_active !== want.active) begin
					mismatches++;
					$display("%0t: active_count expected %0d actual %0d",
						$time, want.active, got_active);
				end
				if (got_heater !== want.heater) begin
					mismatches++;
					$display("%0t: has_heater expected %b actual %b",
						$time, want.heater, got_heater);
				end
			end
		end
	end

	// Watchdog: too long with no transaction on any channel ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// flags = {fan_on, cooling_fan_on, convection_fan_on, elements_on}
	task automatic post(input logic [CMD_W-1:0] command, input logic [KIND_W-1:0] kind,
			input logic [DUTY_W-1:0] duty, input logic [3:0] flags, input bit sync);
		oven_cmd_t c;
		c.command = command;
		c.kind = kind;
		c.duty = duty;
		{c.fan_on, c.cool_on, c.conv_on, c.elements_on} = flags;
		c.wait_idle = sync;
		pending.push_back(c);
		n_queued++;
	endtask

	// Mostly ticks so the PWM really cycles, with duty changes mixed in
	task automatic post_random(input bit sync);
		int r, pick;
		logic [CMD_W-1:0]  command;
		logic [KIND_W-1:0] kind;
		logic [DUTY_W-1:0] duty;
		r = $urandom_range(0, 99);
		kind = ($urandom_range(0, 15) == 0) ? KIND_SPARE : KIND_W'($urandom_range(0, 2));
		duty = DUTY_W'($urandom_range(0, (1 << DUTY_W) - 1));
		if (r < 60) begin
			command = CMD_TICK;
		end else if (r < 76) begin
			command = CMD_SET_DUTY;
			pick = $urandom_range(0, 19);
			case (pick)
				0: duty = '0;
				1: duty = DUTY_W'(PERIOD);
				2: duty = DUTY_W'($urandom_range(PERIOD + 1, (1 << DUTY_W) - 1));
				3: duty = DUTY_W'(PERIOD - 1);
				default: duty = DUTY_W'($urandom_range(1, PERIOD - 1));
			endcase
		end else if (r < 83) begin
			command = CMD_SET_OVEN;
		end else if (r < 89) begin
			command = CMD_CONV_FAN;
		end else if (r < 95) begin
			command = CMD_COOL_FAN;
		end else if (r < 98) begin
			command = CMD_RESTART;
		end else begin
			command = r[0] ? CMD_SPARE_A : CMD_SPARE_B;
		end
		// elements_on mostly high so heaters are not always forced off
		post(command, kind, duty, {$urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
			$urandom_range(0, 1) == 1, $urandom_range(0, 3) != 0}, sync);
	endtask

	// One output layout with a bias toward heaters
	function automatic logic [TYPES_W-1:0] random_layout();
		logic [TYPES_W-1:0] lay;
		int r;
		for (int i = 0; i < NOUT; i++) begin
			r = $urandom_range(0, 15);
			if (r == 0)
				lay[TYPE_W*i +: TYPE_W] = OT_UNUSED;
			else if (r == 1)
				lay[TYPE_W*i +: TYPE_W] = $urandom_range(0, 1) ? TYPE_SPARE_A : TYPE_SPARE_B;
			else if (r < 4)
				lay[TYPE_W*i +: TYPE_W] = OT_CONV;
			else if (r < 6)
				lay[TYPE_W*i +: TYPE_W] = OT_COOL;
			else
				lay[TYPE_W*i +: TYPE_W] = TYPE_W'(OT_BOTTOM) + TYPE_W'($urandom_range(0, 2));
		end
		return lay;
	endfunction

	// Register write; only called while nothing is in flight
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TYPES_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_OUTPUT_TYPES)
			cfg_types = value;
		else
			cfg_invert = value[NOUT-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_layout(input logic [TYPES_W-1:0] lay, input logic [NOUT-1:0] inv);
		write_reg(REG_OUTPUT_TYPES, lay);
		write_reg(REG_INVERT_MASK, TYPES_W'(inv));
		n_layouts++;
	endtask

	// Every command yields one result, so idle means all queued ones checked;
	// the short tail covers the two-stage pipeline
	task automatic drain();
		do @(posedge clk); while (n_checked != n_queued);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int count;
		logic [TYPES_W-1:0] lay;
		logic [NOUT-1:0] inv;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_taken = 1'b0;
		quiet = 1'b0;
		in_gap = 0;
		out_gap = 0;
		idle_cycles = 0;
		n_queued = 0;
		n_accepted = 0;
		n_checked = 0;
		n_ticks = 0;
		n_layouts = 0;
		mismatches = 0;
		// predictor reset state: staggered phases, nothing on, registers zero
		cfg_types = '0;
		cfg_invert = '0;
		level_bits = '0;
		for (int i = 0; i < NOUT; i++)
			pwm_phase[i] = DUTY_W'((STEP * (i + 1)) % PERIOD);
		for (int k = 0; k < NUM_KINDS; k++)
			heat_duty[k] = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset layout: no active outputs at all
		post(CMD_TICK, KIND_BOTTOM, '0, 4'b0000, 0);
		post(CMD_SET_OVEN, KIND_BOTTOM, '0, 4'b1111, 0);
		post(CMD_CONV_FAN, KIND_BOTTOM, '0, 4'b1000, 0);
		drain();

		// An output of every used type, bottom twice, alternate pins inverted
		set_layout({OT_BOTTOM, OT_COOL, OT_CONV, OT_BOOST, OT_TOP, OT_BOTTOM}, 6'b101010);
		post(CMD_SET_DUTY, KIND_BOTTOM, '0, 4'b0000, 0);
		post(CMD_SET_DUTY, KIND_TOP, DUTY_W'(PERIOD), 4'b0000, 0);
		post(CMD_SET_DUTY, KIND_BOOST, '1, 4'b0000, 0);        // above the period
		post(CMD_SET_DUTY, KIND_SPARE, DUTY_W'(55), 4'b0000, 0); // spare kind, no effect
		post(CMD_TICK, KIND_BOTTOM, '0, 4'b0000, 0);
		post(CMD_TICK, KIND_BOTTOM, '0, 4'b0000, 0);
		post(CMD_SET_OVEN, KIND_BOTTOM, '0, 4'b0111, 0);       // elements on, both fans on
		post(CMD_CONV_FAN, KIND_BOTTOM, '0, 4'b0000, 0);
		post(CMD_COOL_FAN, KIND_BOTTOM, '0, 4'b1000, 0);
		post(CMD_RESTART, KIND_BOTTOM, '0, 4'b0000, 0);
		post(CMD_SET_DUTY, KIND_TOP, DUTY_W'(PERIOD), 4'b0000, 0);
		post(CMD_SET_DUTY, KIND_BOOST, DUTY_W'(1), 4'b0000, 0);
		post(CMD_TICK, KIND_BOTTOM, '0, 4'b0000, 0);
		post(CMD_TICK, KIND_BOTTOM, '0, 4'b0000, 0);
		post(CMD_TICK, KIND_BOTTOM, '0, 4'b0000, 0);
		post(CMD_SET_OVEN, KIND_BOTTOM, '0, 4'b1100, 0);       // elements off
		post(CMD_SPARE_A, KIND_SPARE, '1, 4'b1111, 0);
		post(CMD_SPARE_B, KIND_SPARE, '1, 4'b1111, 0);
		post(CMD_SET_DUTY, KIND_BOTTOM, DUTY_W'(1), 4'b0000, 0);
		drain();

		// Random phases, each under its own layout
		for (int ph = 0; ph < 7; ph++) begin
			count = 300;
			inv = NOUT'($urandom_range(0, (1 << NOUT) - 1));
			case (ph)
				0: begin
					// all heaters, no inversion
					for (int i = 0; i < NOUT; i++)
						lay[TYPE_W*i +: TYPE_W] = TYPE_W'(OT_BOTTOM) + TYPE_W'($urandom_range(0, 2));
					inv = '0;
				end
				1: begin
					// every code spare: nothing active, every pin inverted
					lay = '1;
					inv = '1;
					count = 80;
				end
				2: begin
					for (int i = 0; i < NOUT; i++)
						lay[TYPE_W*i +: TYPE_W] = $urandom_range(0, 1) ? OT_CONV : OT_COOL;
				end
				5: begin
					// run broken by a spare code: outputs past it stay inactive
					lay = random_layout();
					lay[TYPE_W*2 +: TYPE_W] = TYPE_SPARE_A;
				end
				default: lay = random_layout();
			endcase
			quiet = (ph == 6);
			set_layout(lay, inv);
			for (int k = 0; k < count; k++)
				post_random(k == count / 2 || $urandom_range(0, 199) == 0);
			drain();
		end

		$display("Checked %0d results from %0d commands (%0d PWM ticks) across %0d layouts,",
			n_checked, n_accepted, n_ticks, n_layouts);
		$display("with random stalls on both streams and %0d field mismatches.", mismatches);
		if (mismatches == 0 && status_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
